/* design/lunar_month_stepper_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the lunar month stepper
// Shared forms for the concurrent checks in the design files.
// ---------------------------------------------------------------------------
`ifndef LUNAR_MONTH_STEPPER_UNIT_DEFINES_SVH
`define LUNAR_MONTH_STEPPER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define LMS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that, when seen, must be followed by another on the next edge.
`define LMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/lms_pkg.sv */
// ---------------------------------------------------------------------------
// Lunar month stepper package
// Shared types, field widths and code constants for the month stepper.
// ---------------------------------------------------------------------------
package lms_pkg;

    // Field widths.
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned TYPE_W  = 2;
    localparam int unsigned ZREM_W  = 6;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 6;

    // Bounds.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = '1;

    // Item kinds.
    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_LOAD    = 1'b1;

    // Month type codes.
    localparam logic [TYPE_W-1:0] TYPE_NORMAL = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_FIRST  = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_SECOND = 2'd2;

    // Calendar systems.
    localparam logic SYS_PHUGPA  = 1'b0;
    localparam logic SYS_TSURPHU = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZREM   = 1'd1;

    // Reset values.
    localparam logic [ZREM_W-1:0]  ZREM_RESET  = 6'd48;
    localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;

    // One input word.
    typedef struct packed {
        logic               kind;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   idx;
        logic [MONTH_W-1:0] exp_month;
        logic [MONTH_W-1:0] month;
        logic [TYPE_W-1:0]  mtype;
        logic               zero;
    } item_t;

    // Calendar state carried from month to month.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   idx;
        logic [MONTH_W-1:0] exp_month;
        logic [MONTH_W-1:0] month;
        logic [TYPE_W-1:0]  mtype;
        logic               zero;
    } state_t;

    // Configuration registers.
    typedef struct packed {
        logic              system;
        logic [ZREM_W-1:0] zrem;
    } cfg_t;

endpackage

/* design/lunar_month_stepper_unit.sv */
// ---------------------------------------------------------------------------
// Lunar month stepper
// Steps a lunisolar calendar one month per word, or loads a start month.
// ---------------------------------------------------------------------------
// Usage: each word on the s_ channel either advances the calendar by one
// month (kind 0) or loads the whole calendar state from its fields (kind 1).
// Every word gives exactly one word on the m_ channel holding the state
// after the step, plus a flag for a year increment.
// The cfg_ channel writes the calendar system (index 0) and the Phugpa
// intercalation remainder (index 1); it is always ready. The user must write
// it only while no word is in flight; the block itself does not enforce this.
// From input acceptance to m_valid, the word sits in the input register, then
// one pass through the step logic loads the result register. Throughput is
// one word per cycle while the receiver does not stall, set by the combinational
// step logic feeding back into the state registers.
// When the receiver stalls, the result register holds, the input register
// holds its word, and s_ready drops once both are full.
// Reset clears the state to year 0, count 0, remainder 0, month 1, normal
// type, and the registers to the Phugpa rule with remainder 48.
// ---------------------------------------------------------------------------
`include "lunar_month_stepper_unit_defines.svh"

module lunar_month_stepper_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lms_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [lms_pkg::YEAR_W-1:0]      s_load_year,
    input  logic [lms_pkg::COUNT_W-1:0]     s_load_month_count,
    input  logic [lms_pkg::IDX_W-1:0]       s_load_index,
    input  logic [lms_pkg::MONTH_W-1:0]     s_load_expected_month,
    input  logic [lms_pkg::MONTH_W-1:0]     s_load_month,
    input  logic [lms_pkg::TYPE_W-1:0]      s_load_type,
    input  logic                            s_load_zero_flag,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lms_pkg::MONTH_W-1:0]     m_month_number,
    output logic [lms_pkg::TYPE_W-1:0]      m_month_type,
    output logic [lms_pkg::YEAR_W-1:0]      m_year_number,
    output logic [lms_pkg::COUNT_W-1:0]     m_month_count,
    output logic [lms_pkg::IDX_W-1:0]       m_intercalation_index,
    output logic                            m_repeat_pending,
    output logic                            m_new_year
);
    import lms_pkg::*;

    logic   cfg_system_reg;
    logic [ZREM_W-1:0] cfg_zrem_reg;
    cfg_t   cfg;

    logic   in_valid_reg;
    item_t  in_item_reg;
    item_t  s_item;

    state_t state_reg;
    state_t state_next;
    logic   new_year_next;

    logic   out_valid_reg;
    state_t out_state_reg;
    logic   out_new_year_reg;

    logic   advance;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    assign cfg.system = cfg_system_reg;
    assign cfg.zrem   = cfg_zrem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_system_reg <= SYS_PHUGPA;
            cfg_zrem_reg   <= ZREM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SYSTEM: cfg_system_reg <= cfg_data[0];
                CFG_ZREM:   cfg_zrem_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Input register stage.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign s_item.kind      = s_kind;
    assign s_item.year      = s_load_year;
    assign s_item.count     = s_load_month_count;
    assign s_item.idx       = s_load_index;
    assign s_item.exp_month = s_load_expected_month;
    assign s_item.month     = s_load_month;
    assign s_item.mtype     = s_load_type;
    assign s_item.zero      = s_load_zero_flag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Month step logic.
    lms_step u_step (
        .item     (in_item_reg),
        .cur      (state_reg),
        .cfg      (cfg),
        .nxt      (state_next),
        .new_year (new_year_next)
    );

    // Calendar state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.year      <= '0;
            state_reg.count     <= '0;
            state_reg.idx       <= '0;
            state_reg.exp_month <= MONTH_RESET;
            state_reg.month     <= MONTH_RESET;
            state_reg.mtype     <= TYPE_NORMAL;
            state_reg.zero      <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg    <= state_next;
            out_new_year_reg <= new_year_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_month_number        = out_state_reg.month;
    assign m_month_type          = out_state_reg.mtype;
    assign m_year_number         = out_state_reg.year;
    assign m_month_count         = out_state_reg.count;
    assign m_intercalation_index = out_state_reg.idx;
    assign m_repeat_pending      = out_state_reg.zero;
    assign m_new_year            = out_new_year_reg;

    // Checks.
    `LMS_ASSERT_ALWAYS(a_new_year_month,
        !(m_valid && m_new_year) ||
        (m_month_number == 4'd1 && m_month_type != TYPE_SECOND),
        "new year flagged on a month that cannot open a year")
    `LMS_ASSERT_ALWAYS(a_result_matches_state,
        !m_valid || (out_state_reg == state_reg),
        "shown result differs from the calendar state")
    `LMS_ASSERT_NEXT(a_load_no_new_year,
        advance && in_item_reg.kind == KIND_LOAD,
        !out_new_year_reg,
        "a load word raised the new year flag")
    `LMS_ASSERT_NEXT(a_stall_keeps_word,
        in_valid_reg && out_valid_reg && !m_ready,
        in_valid_reg && $stable(in_item_reg) && $stable(state_reg),
        "input word or state moved while the result was stalled")

endmodule

/* design/lms_step.sv */
// ---------------------------------------------------------------------------
// Lunar month step logic
// Computes the calendar state after one advance or load word.
// ---------------------------------------------------------------------------
module lms_step (
    input  lms_pkg::item_t  item,
    input  lms_pkg::state_t cur,
    input  lms_pkg::cfg_t   cfg,
    output lms_pkg::state_t nxt,
    output logic            new_year
);
    import lms_pkg::*;

    logic [IDX_W:0]       r_sum;
    logic [1:0]           step;
    logic [COUNT_W:0]     up_sum;
    logic [COUNT_W-1:0]   cnt;
    logic [IDX_W-1:0]     idx;
    logic [MONTH_W-1:0]   em;
    logic [MONTH_W:0]     em_inc;
    logic                 zp;
    logic [IDX_W-1:0]     z_lo;
    logic [IDX_W-1:0]     z_hi;
    logic                 first;
    logic                 dec;
    logic [MONTH_W-1:0]   month;
    logic [TYPE_W-1:0]    mtype;

    always_comb begin
        r_sum    = {1'b0, cur.idx} + 8'd2;
        em_inc   = {1'b0, cur.exp_month} + 5'd1;
        z_lo     = {1'b0, cfg.zrem};
        z_hi     = {1'b0, cfg.zrem} + 7'd1;
        step     = 2'd1;
        up_sum   = '0;
        cnt      = cur.count;
        idx      = cur.idx;
        em       = cur.exp_month;
        zp       = cur.zero;
        first    = 1'b0;
        dec      = 1'b0;
        month    = '0;
        mtype    = TYPE_NORMAL;
        new_year = 1'b0;
        nxt      = cur;

        if (item.kind == KIND_LOAD) begin
            nxt.year      = item.year;
            nxt.count     = item.count;
            nxt.idx       = item.idx;
            nxt.exp_month = item.exp_month;
            nxt.month     = item.month;
            nxt.mtype     = item.mtype;
            nxt.zero      = item.zero;
        end else begin
            // Move the true month on by 1;2 unless a repeat is pending.
            if (!zp) begin
                if (r_sum >= 8'd65) begin
                    idx  = 7'(r_sum - 8'd65);
                    step = 2'd2;
                end else begin
                    idx  = r_sum[IDX_W-1:0];
                    step = 2'd1;
                end
                up_sum = {1'b0, cnt} + 25'(step);
                cnt    = up_sum[COUNT_W] ? COUNT_MAX : up_sum[COUNT_W-1:0];

                // Expected month, with the drop back at the end of the year.
                if (cur.month == 4'd12 && cur.mtype != TYPE_FIRST) begin
                    em = (cur.exp_month >= 4'd12) ? cur.exp_month - 4'd11 : 4'd1;
                end else begin
                    em = (em_inc >= 5'd15) ? 4'd1 : em_inc[MONTH_W-1:0];
                end
            end

            // Apply the intercalation rule of the selected system.
            month = em;
            if (cfg.system == SYS_TSURPHU) begin
                if (idx == 7'd0 || idx == 7'd1) begin
                    if (!zp) begin
                        zp    = 1'b1;
                        cnt   = (cnt == '0) ? cnt : cnt - 24'd1;
                        first = (em != '0);
                    end else begin
                        zp  = 1'b0;
                        cnt = (cnt == COUNT_MAX) ? cnt : cnt + 24'd1;
                    end
                end
            end else begin
                if (idx == z_lo || idx == z_hi) begin
                    first = (em != '0);
                end else begin
                    if (idx > z_hi) begin
                        dec = 1'b1;
                    end else if (idx == 7'd0 || idx == 7'd1) begin
                        if (!zp) begin
                            zp  = 1'b1;
                            dec = 1'b1;
                            cnt = (cnt == '0) ? cnt : cnt - 24'd1;
                        end else begin
                            zp  = 1'b0;
                            cnt = (cnt == COUNT_MAX) ? cnt : cnt + 24'd1;
                        end
                    end
                    // The month before a doubled one is shown one lower.
                    if (dec) begin
                        if (em == 4'd0) begin
                            first = 1'b1;
                            month = 4'd1;
                        end else if (em == 4'd1) begin
                            month = 4'd12;
                        end else begin
                            month = em - 4'd1;
                        end
                    end else if (em == 4'd0) begin
                        month = 4'd12;
                    end
                end
            end

            // Month type follows the previous one unless a doubling starts.
            mtype = (cur.mtype == TYPE_FIRST) ? TYPE_SECOND : TYPE_NORMAL;
            if (first) begin
                mtype = TYPE_FIRST;
            end

            nxt.count     = cnt;
            nxt.idx       = idx;
            nxt.exp_month = em;
            nxt.month     = month;
            nxt.mtype     = mtype;
            nxt.zero      = zp;

            // A new year starts with month 1 that is not a repeat.
            if (month == 4'd1 && mtype != TYPE_SECOND && cur.year != YEAR_MAX) begin
                nxt.year = cur.year + 16'd1;
                new_year = 1'b1;
            end
        end
    end

endmodule

/* sim/lunar_month_stepper_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lunar month stepper testbench
// Drives advance and load words through the stepper under several calendar
// settings. It predicts each result word from its own copy of the calendar
// state and compares every result field by field.
// ---------------------------------------------------------------------------
module lunar_month_stepper_unit_tb;
    import lms_pkg::*;

    // Step arithmetic and run control.
    localparam int REMAINDER_MOD   = 65;
    localparam int EXP_MONTH_LIMIT = 15;
    localparam int YEAR_END_DROP   = 11;
    localparam int LAST_MONTH      = 12;
    localparam logic [TYPE_W-1:0] TYPE_UNUSED = 2'd3;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int unsigned RUN_LIMIT = 600000;

    // One result word as the block presents it.
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [TYPE_W-1:0]  mtype;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   idx;
        logic               zero;
        logic               new_year;
    } month_result_t;

    // Calendar predictor and the queue of result words still to come.
    class month_scoreboard;
        cfg_t          regs;
        state_t        cal;
        month_result_t expected_q[$];
        int            errors;

        function new();
            regs.system = SYS_PHUGPA;
            regs.zrem   = ZREM_RESET;
            cal         = '0;
            cal.exp_month = MONTH_RESET;
            cal.month     = MONTH_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SYSTEM)
                regs.system = data[0];
            else if (idx == CFG_ZREM)
                regs.zrem = data[ZREM_W-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // The true-month count saturates at both ends.
        function void count_up(int n);
            int room;
            room = int'(COUNT_MAX - cal.count);
            if (n > room)
                cal.count = COUNT_MAX;
            else
                cal.count = cal.count + COUNT_W'(n);
        endfunction

        function void count_down();
            if (cal.count != 0)
                cal.count = cal.count - COUNT_W'(1);
        endfunction

        // Applies the intercalation rule. A negative result marks the first
        // month of a doubled pair.
        function int adjusted_month(int tm);
            int idx;
            int z;
            int adj;
            idx = int'(cal.idx);
            z   = int'(regs.zrem);
            if (regs.system == SYS_TSURPHU) begin
                if (idx <= 1) begin
                    if (!cal.zero) begin
                        cal.zero = 1'b1;
                        count_down();
                        return -tm;
                    end
                    cal.zero = 1'b0;
                    count_up(1);
                end
                return tm;
            end
            if (idx == z || idx == z + 1)
                return -tm;
            if (idx > z + 1) begin
                adj = tm - 1;
            end else if (idx <= 1) begin
                if (!cal.zero) begin
                    cal.zero = 1'b1;
                    adj = tm - 1;
                    count_down();
                end else begin
                    cal.zero = 1'b0;
                    adj = tm;
                    count_up(1);
                end
            end else begin
                adj = tm;
            end
            if (adj == 0)
                adj = LAST_MONTH;
            return adj;
        endfunction

        // Steps the predicted calendar for one accepted input word.
        function void note_word(item_t w);
            month_result_t res;
            int r;
            int tm;
            int adj;
            logic grew;
            grew = 1'b0;
            if (w.kind == KIND_LOAD) begin
                cal.year      = w.year;
                cal.count     = w.count;
                cal.idx       = w.idx;
                cal.exp_month = w.exp_month;
                cal.month     = w.month;
                cal.mtype     = w.mtype;
                cal.zero      = w.zero;
            end else begin
                if (!cal.zero) begin
                    r = int'(cal.idx) + 2;
                    cal.idx = IDX_W'(r % REMAINDER_MOD);
                    count_up(1 + r / REMAINDER_MOD);
                    if (cal.month == LAST_MONTH && cal.mtype != TYPE_FIRST) begin
                        if (cal.exp_month >= LAST_MONTH)
                            cal.exp_month = cal.exp_month - MONTH_W'(YEAR_END_DROP);
                        else
                            cal.exp_month = MONTH_W'(1);
                    end else begin
                        tm = int'(cal.exp_month) + 1;
                        cal.exp_month = MONTH_W'((tm >= EXP_MONTH_LIMIT) ? 1 : tm);
                    end
                end
                adj = adjusted_month(int'(cal.exp_month));
                cal.mtype = (cal.mtype == TYPE_FIRST) ? TYPE_SECOND : TYPE_NORMAL;
                if (adj < 0) begin
                    cal.mtype = TYPE_FIRST;
                    cal.month = MONTH_W'(-adj);
                end else begin
                    cal.month = MONTH_W'(adj);
                end
                if (cal.month == 1 && cal.mtype != TYPE_SECOND && cal.year != YEAR_MAX) begin
                    cal.year = cal.year + YEAR_W'(1);
                    grew = 1'b1;
                end
            end
            res = '{cal.month, cal.mtype, cal.year, cal.count, cal.idx, cal.zero, grew};
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compares one result word with the oldest prediction.
        function void check_word(month_result_t got);
            month_result_t want;
            if (expected_q.size() == 0) begin
                $error("result word arrived with no word expected");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("month_number", 32'(want.month), 32'(got.month));
            compare_field("month_type", 32'(want.mtype), 32'(got.mtype));
            compare_field("year_number", 32'(want.year), 32'(got.year));
            compare_field("month_count", 32'(want.count), 32'(got.count));
            compare_field("intercalation_index", 32'(want.idx), 32'(got.idx));
            compare_field("repeat_pending", 32'(want.zero), 32'(got.zero));
            compare_field("new_year", 32'(want.new_year), 32'(got.new_year));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [YEAR_W-1:0]     s_load_year;
    logic [COUNT_W-1:0]    s_load_month_count;
    logic [IDX_W-1:0]      s_load_index;
    logic [MONTH_W-1:0]    s_load_expected_month;
    logic [MONTH_W-1:0]    s_load_month;
    logic [TYPE_W-1:0]     s_load_type;
    logic                  s_load_zero_flag;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [MONTH_W-1:0]    m_month_number;
    logic [TYPE_W-1:0]     m_month_type;
    logic [YEAR_W-1:0]     m_year_number;
    logic [COUNT_W-1:0]    m_month_count;
    logic [IDX_W-1:0]      m_intercalation_index;
    logic                  m_repeat_pending;
    logic                  m_new_year;

    month_scoreboard sb = new();
    bit              tx_gaps = 1'b0;
    bit              rx_stalls = 1'b0;
    int              rx_hold = 0;
    int unsigned     cycle_count = 0;

    lunar_month_stepper_unit dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_kind                (s_kind),
        .s_load_year           (s_load_year),
        .s_load_month_count    (s_load_month_count),
        .s_load_index          (s_load_index),
        .s_load_expected_month (s_load_expected_month),
        .s_load_month          (s_load_month),
        .s_load_type           (s_load_type),
        .s_load_zero_flag      (s_load_zero_flag),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_month_number        (m_month_number),
        .m_month_type          (m_month_type),
        .m_year_number         (m_year_number),
        .m_month_count         (m_month_count),
        .m_intercalation_index (m_intercalation_index),
        .m_repeat_pending      (m_repeat_pending),
        .m_new_year            (m_new_year)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    // The receiver stalls at random while stalls are enabled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            rx_hold <= gap_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted result word goes to the checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            sb.check_word('{m_month_number, m_month_type, m_year_number, m_month_count,
                            m_intercalation_index, m_repeat_pending, m_new_year});
    end

    // A hung handshake ends the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL lunar_month_stepper_unit");
            $finish;
        end
    end

    // Writes both registers back to back and updates the predictor.
    task automatic set_calendar(logic system, logic [ZREM_W-1:0] zrem);
        logic [CFG_DATA_W-1:0] sys_word;
        sys_word    = CFG_DATA_W'($urandom);
        sys_word[0] = system;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SYSTEM;
        cfg_data  <= sys_word;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_SYSTEM, sys_word);
        cfg_index <= CFG_ZREM;
        cfg_data  <= zrem;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_ZREM, zrem);
        cfg_valid <= 1'b0;
    endtask

    // Presents one word and holds it until the block takes it.
    task automatic send_word(item_t w);
        s_valid               <= 1'b1;
        s_kind                <= w.kind;
        s_load_year           <= w.year;
        s_load_month_count    <= w.count;
        s_load_index          <= w.idx;
        s_load_expected_month <= w.exp_month;
        s_load_month          <= w.month;
        s_load_type           <= w.mtype;
        s_load_zero_flag      <= w.zero;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    task automatic idle_sender();
        int n;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            n = gap_len();
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Holds off the sender until every expected word has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Advance words carry random payload that the block must ignore.
    function automatic item_t make_advance();
        item_t w;
        w.kind      = KIND_ADVANCE;
        w.year      = YEAR_W'($urandom);
        w.count     = COUNT_W'($urandom);
        w.idx       = IDX_W'($urandom);
        w.exp_month = MONTH_W'($urandom);
        w.month     = MONTH_W'($urandom);
        w.mtype     = TYPE_W'($urandom);
        w.zero      = 1'($urandom);
        return w;
    endfunction

    // Loads are mostly in range; broken ones push the remainder, and at random the months and type, past their range.
    function automatic item_t make_load(bit broken);
        item_t w;
        w.kind      = KIND_LOAD;
        w.year      = YEAR_W'($urandom);
        w.count     = COUNT_W'($urandom);
        w.idx       = IDX_W'($urandom_range(0, REMAINDER_MOD - 1));
        w.exp_month = MONTH_W'($urandom_range(1, 14));
        w.month     = MONTH_W'($urandom_range(1, 14));
        w.mtype     = TYPE_W'($urandom_range(TYPE_NORMAL, TYPE_SECOND));
        w.zero      = 1'($urandom);
        if ($urandom_range(0, 7) == 0)
            w.year = YEAR_MAX - YEAR_W'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0)
            w.count = COUNT_MAX - COUNT_W'($urandom_range(0, 3));
        if (broken) begin
            w.idx = IDX_W'($urandom_range(REMAINDER_MOD, 127));
            if ($urandom_range(0, 1) == 0)
                w.exp_month = $urandom_range(0, 1) ? 4'd0 : 4'd15;
            if ($urandom_range(0, 1) == 0)
                w.month = $urandom_range(0, 1) ? 4'd0 : 4'd15;
            if ($urandom_range(0, 1) == 0)
                w.mtype = TYPE_UNUSED;
        end
        return w;
    endfunction

    task automatic send_load(logic [YEAR_W-1:0] year, logic [COUNT_W-1:0] count,
                             logic [IDX_W-1:0] idx, logic [MONTH_W-1:0] exp_m,
                             logic [MONTH_W-1:0] month, logic [TYPE_W-1:0] mtype,
                             logic zero);
        item_t w;
        w = '{KIND_LOAD, year, count, idx, exp_m, month, mtype, zero};
        send_word(w);
    endtask

    // Directed words under the Phugpa rule with remainder 48.
    task automatic run_directed();
        send_word(make_advance());
        // Plain start of the count.
        send_load(16'd0, 24'd0, 7'd0, 4'd1, 4'd1, TYPE_NORMAL, 1'b0);
        send_word(make_advance());
        // Year and count both at their upper bounds across a new year.
        send_load(YEAR_MAX, COUNT_MAX, 7'd20, 4'd12, 4'd12, TYPE_NORMAL, 1'b0);
        send_word(make_advance());
        // Year end with a small expected month.
        send_load(16'd100, 24'd5000, 7'd20, 4'd5, 4'd12, TYPE_NORMAL, 1'b0);
        send_word(make_advance());
        // Expected month running past fourteen.
        send_load(16'd7, 24'd9, 7'd20, 4'd14, 4'd13, TYPE_NORMAL, 1'b0);
        send_word(make_advance());
        // Unused type code.
        send_load(16'd8, 24'd10, 7'd20, 4'd6, 4'd6, TYPE_UNUSED, 1'b0);
        send_word(make_advance());
        // Expected month zero on a doubled month, then just past one.
        send_load(16'd9, 24'd11, 7'd48, 4'd0, 4'd3, TYPE_NORMAL, 1'b1);
        send_word(make_advance());
        send_load(16'd9, 24'd11, 7'd55, 4'd0, 4'd3, TYPE_NORMAL, 1'b1);
        send_word(make_advance());
        // Remainder beyond the modulus.
        send_load(16'd10, 24'd12, 7'd100, 4'd5, 4'd5, TYPE_NORMAL, 1'b0);
        send_word(make_advance());
        // Skipped month at remainder zero, then the repeat.
        send_load(16'd11, 24'd13, 7'd63, 4'd11, 4'd11, TYPE_NORMAL, 1'b0);
        send_word(make_advance());
        send_word(make_advance());
        // Doubled month at the intercalation remainder.
        send_load(16'd12, 24'd14, 7'd46, 4'd3, 4'd3, TYPE_NORMAL, 1'b0);
        send_word(make_advance());
        send_word(make_advance());
        // Every load field at all ones.
        send_load(YEAR_MAX, COUNT_MAX, 7'h7F, 4'd15, 4'd15, TYPE_UNUSED, 1'b1);
        send_word(make_advance());
    endtask

    initial begin
        item_t            w;
        int               roll;
        logic             sys;
        logic [ZREM_W-1:0] zrem;
        aresetn               <= 1'b0;
        cfg_valid             <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        s_valid               <= 1'b0;
        s_kind                <= 1'b0;
        s_load_year           <= '0;
        s_load_month_count    <= '0;
        s_load_index          <= '0;
        s_load_expected_month <= '0;
        s_load_month          <= '0;
        s_load_type           <= '0;
        s_load_zero_flag      <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_calendar(SYS_PHUGPA, ZREM_RESET);
        run_directed();
        drain();

        // Random phases, each under its own calendar setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            unique case (p)
                0: begin sys = SYS_PHUGPA;  zrem = ZREM_RESET; end
                1: begin sys = SYS_PHUGPA;  zrem = 6'd2;  end
                2: begin sys = SYS_TSURPHU; zrem = ZREM_W'($urandom); end
                3: begin sys = SYS_PHUGPA;  zrem = 6'd63; end
                4: begin sys = SYS_PHUGPA;  zrem = 6'd0;  end
                5: begin sys = SYS_PHUGPA;  zrem = 6'd1;  end
                6: begin sys = SYS_TSURPHU; zrem = 6'd63; end
                default: begin
                    sys  = SYS_PHUGPA;
                    zrem = ZREM_W'($urandom_range(2, 63));
                end
            endcase
            set_calendar(sys, zrem);
            tx_gaps   = (p != 0);
            rx_stalls = (p != 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2)
                    drain();
                if (p != 0 && i % 50 == 0) begin
                    tx_gaps   = ($urandom_range(0, 3) != 0);
                    rx_stalls = ($urandom_range(0, 3) != 0);
                end
                roll = int'($urandom_range(0, 31));
                if (roll == 0)
                    w = make_load(1'b1);
                else if (roll < 3)
                    w = make_load(1'b0);
                else
                    w = make_advance();
                send_word(w);
                idle_sender();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("PASS lunar_month_stepper_unit");
        else
            $display("FAIL lunar_month_stepper_unit");
        $finish;
    end

endmodule
